>>> hw/rtl/isra_pkg.sv
`default_nettype none
package isra_pkg;

	localparam int ID_W          = 32;
	localparam int NODE_W        = 16;
	localparam int SLOT_W        = 5;
	localparam int CFG_DATA_W    = 32;
	localparam int CFG_ADDR_W    = 5;
	localparam int NUM_PREF_REGS = 6;
	// entries of the preferred list that take part in the lookup
	localparam int PREF_COUNT    = 6;

	typedef enum logic [2:0] {
		REG_PREF_A = 3'd0,
		REG_PREF_B = 3'd1,
		REG_PREF_C = 3'd2,
		REG_PREF_D = 3'd3,
		REG_PREF_E = 3'd4,
		REG_PREF_F = 3'd5
	} cfg_reg_t;

endpackage
`default_nettype wire

>>> hw/rtl/isra_ram.sv
`default_nettype none
module isra_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

>>> hw/rtl/id_slot_register_allocator_unit.sv
`default_nettype none
// Registration slot table. SLOT_COUNT slots each hold a 32-bit ID (0 = free) and
// the handle of the head node of that ID's list. A command is taken when start
// is high while busy is low; reg_id and node_handle are sampled at that edge.
// The block then sweeps the ID memory one slot per cycle. The lowest slot that
// holds the ID gets the new node as head and the old head comes back on
// next_node. With no such slot, a free slot is claimed (the lowest one when the
// ID is in the preferred list pref_id_a..f, which ends at its first zero entry,
// else the highest one) and claimed is set. With no free slot, ok is 0 and the
// table is untouched. An ID of 0 matches the lowest free slot as an existing
// entry, which stays free. Each command yields exactly one result, shown for a
// single cycle with done high; the receiver cannot stall it, so it must take it
// in that cycle. A command finishes sooner when the ID is found early; the sweep
// is bounded by the single read port of the slot memories, which serves one slot
// per cycle. busy drops in the cycle done is shown, so the next command can be
// taken there. Slot contents are cleared at reset through per-slot valid flops:
// no clearing sweep, the block is ready right after reset. The preferred-ID
// registers sit on the APB port at byte addresses 0x00..0x14 and read back;
// paddr[1:0] is ignored, and addresses 0x18..0x1F read 0 and ignore writes.
module id_slot_register_allocator_unit #(
	parameter int SLOT_COUNT  = 32,
	parameter int HANDLE_BITS = 16
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// command channel
	input  wire logic                               start,
	output logic                                    busy,
	input  wire logic [isra_pkg::ID_W-1:0]          reg_id,
	input  wire logic [isra_pkg::NODE_W-1:0]        node_handle,
	// result channel
	output logic                                    done,
	output logic                                    ok,
	output logic      [isra_pkg::SLOT_W-1:0]        slot,
	output logic                                    claimed,
	output logic      [isra_pkg::NODE_W-1:0]        next_node,
	// configuration port
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic [isra_pkg::CFG_ADDR_W-1:0]    paddr,
	input  wire logic [isra_pkg::CFG_DATA_W-1:0]    pwdata,
	output logic      [isra_pkg::CFG_DATA_W-1:0]    prdata,
	output logic                                    pready
);

	import isra_pkg::*;

	localparam int IDX_W = $clog2(SLOT_COUNT);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_CLAIM
	} state_t;

	state_t state_q;

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [ID_W-1:0] pref_q [NUM_PREF_REGS];
	logic            cfg_wr;
	cfg_reg_t        cfg_sel;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign cfg_sel = cfg_reg_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PREF_REGS; i++) begin
				pref_q[i] <= '0;
			end
		end else if (cfg_wr) begin
			unique case (cfg_sel)
				REG_PREF_A: pref_q[0] <= pwdata;
				REG_PREF_B: pref_q[1] <= pwdata;
				REG_PREF_C: pref_q[2] <= pwdata;
				REG_PREF_D: pref_q[3] <= pwdata;
				REG_PREF_E: pref_q[4] <= pwdata;
				REG_PREF_F: pref_q[5] <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_sel)
			REG_PREF_A: prdata = pref_q[0];
			REG_PREF_B: prdata = pref_q[1];
			REG_PREF_C: prdata = pref_q[2];
			REG_PREF_D: prdata = pref_q[3];
			REG_PREF_E: prdata = pref_q[4];
			REG_PREF_F: prdata = pref_q[5];
			default:    prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Command latch
	// ------------------------------------------------------------------
	logic                   accept;
	logic [ID_W-1:0]        id_q;
	logic [HANDLE_BITS-1:0] node_q;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start & ~busy;

	always_ff @(posedge clk) begin
		if (accept) begin
			id_q   <= reg_id;
			node_q <= HANDLE_BITS'(node_handle);
		end
	end

	// ------------------------------------------------------------------
	// Slot memories; one valid flop per slot stands in for the reset clear
	// ------------------------------------------------------------------
	logic [SLOT_COUNT-1:0]  slot_vld_q;
	logic                   wr_en;
	logic [IDX_W-1:0]       wr_addr;
	logic [IDX_W-1:0]       rd_addr_q;
	logic [ID_W-1:0]        ram_id;
	logic [HANDLE_BITS-1:0] ram_head;

	isra_ram #(
		.WIDTH (ID_W),
		.DEPTH (SLOT_COUNT)
	) u_id_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (id_q),
		.raddr (rd_addr_q),
		.rdata (ram_id)
	);

	isra_ram #(
		.WIDTH (HANDLE_BITS),
		.DEPTH (SLOT_COUNT)
	) u_head_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (node_q),
		.raddr (rd_addr_q),
		.rdata (ram_head)
	);

	// ------------------------------------------------------------------
	// Scan pipeline: address issued in one cycle, compared in the next
	// ------------------------------------------------------------------
	logic             rd_more_q;
	logic             cmp_vld_s1;
	logic             cmp_last_s1;
	logic [IDX_W-1:0] cmp_idx_s1;

	logic [ID_W-1:0]        eff_id;
	logic [HANDLE_BITS-1:0] eff_head;
	logic                   hit;
	logic                   is_free;

	always_comb begin
		eff_id   = slot_vld_q[cmp_idx_s1] ? ram_id   : '0;
		eff_head = slot_vld_q[cmp_idx_s1] ? ram_head : '0;
		hit      = (state_q == ST_SCAN) && cmp_vld_s1 && (eff_id == id_q);
		is_free  = (eff_id == '0);
	end

	// free-slot tracking over the sweep
	logic             have_free_q;
	logic [IDX_W-1:0] low_free_q;
	logic [IDX_W-1:0] high_free_q;

	// preferred-list membership: the list ends at the first zero entry
	logic pref_hit;
	logic pref_end;

	always_comb begin
		pref_hit = 1'b0;
		pref_end = 1'b0;
		for (int i = 0; i < PREF_COUNT; i++) begin
			if (!pref_end) begin
				if (pref_q[i] == '0) begin
					pref_end = 1'b1;
				end else if (pref_q[i] == id_q) begin
					pref_hit = 1'b1;
					pref_end = 1'b1;
				end
			end
		end
	end

	logic             claim_wr;
	logic [IDX_W-1:0] claim_idx;

	always_comb begin
		claim_idx = pref_hit ? low_free_q : high_free_q;
		claim_wr  = (state_q == ST_CLAIM) && have_free_q;
		wr_en     = hit | claim_wr;
		wr_addr   = hit ? cmp_idx_s1 : claim_idx;
	end

	// ------------------------------------------------------------------
	// Sequencer and result registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			slot_vld_q  <= '0;
			rd_addr_q   <= '0;
			rd_more_q   <= 1'b0;
			cmp_vld_s1  <= 1'b0;
			cmp_last_s1 <= 1'b0;
			cmp_idx_s1  <= '0;
			have_free_q <= 1'b0;
			low_free_q  <= '0;
			high_free_q <= '0;
			done        <= 1'b0;
			ok          <= 1'b0;
			slot        <= '0;
			claimed     <= 1'b0;
			next_node   <= '0;
		end else begin
			if (wr_en) begin
				slot_vld_q[wr_addr] <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					done       <= 1'b0;
					cmp_vld_s1 <= 1'b0;
					if (accept) begin
						state_q     <= ST_SCAN;
						rd_addr_q   <= '0;
						rd_more_q   <= 1'b1;
						have_free_q <= 1'b0;
					end
				end
				ST_SCAN: begin
					done        <= hit;
					// issue side; a hit stops further reads
					cmp_vld_s1  <= rd_more_q;
					cmp_idx_s1  <= rd_addr_q;
					cmp_last_s1 <= (rd_addr_q == LAST_IDX);
					if (hit) begin
						rd_more_q <= 1'b0;
					end else if (rd_more_q) begin
						if (rd_addr_q == LAST_IDX) begin
							rd_more_q <= 1'b0;
						end else begin
							rd_addr_q <= rd_addr_q + 1'b1;
						end
					end
					// compare side
					if (hit) begin
						state_q   <= ST_IDLE;
						ok        <= 1'b1;
						slot      <= SLOT_W'(cmp_idx_s1);
						claimed   <= 1'b0;
						next_node <= NODE_W'(eff_head);
					end else if (cmp_vld_s1) begin
						if (is_free) begin
							if (!have_free_q) begin
								low_free_q <= cmp_idx_s1;
							end
							have_free_q <= 1'b1;
							high_free_q <= cmp_idx_s1;
						end
						if (cmp_last_s1) begin
							state_q <= ST_CLAIM;
						end
					end
				end
				ST_CLAIM: begin
					state_q    <= ST_IDLE;
					cmp_vld_s1 <= 1'b0;
					done       <= 1'b1;
					ok         <= have_free_q;
					slot       <= have_free_q ? SLOT_W'(claim_idx) : '0;
					claimed    <= have_free_q;
					next_node  <= '0;
				end
				default: begin
					state_q <= ST_IDLE;
					done    <= 1'b0;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

>>> hw/rtl/isra_checker.sv
`default_nettype none
module isra_checker (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            start,
	input wire logic                            busy,
	input wire logic [isra_pkg::ID_W-1:0]       reg_id,
	input wire logic [isra_pkg::NODE_W-1:0]     node_handle,
	input wire logic                            done,
	input wire logic                            ok,
	input wire logic [isra_pkg::SLOT_W-1:0]     slot,
	input wire logic                            claimed,
	input wire logic [isra_pkg::NODE_W-1:0]     next_node,
	input wire logic                            psel,
	input wire logic                            penable,
	input wire logic                            pwrite,
	input wire logic [isra_pkg::CFG_ADDR_W-1:0] paddr,
	input wire logic [isra_pkg::CFG_DATA_W-1:0] pwdata,
	input wire logic [isra_pkg::CFG_DATA_W-1:0] prdata,
	input wire logic                            pready
);

	import isra_pkg::*;

	// a transfer in starts work
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted command did not raise busy");

	// a result ends a command that was in flight, and frees the block
	a_done_ends_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(busy) && !busy))
		else $error("result without a command in flight");

	// failure leaves all other result fields clear
	a_fail_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !ok) |-> (slot == '0 && !claimed && next_node == '0))
		else $error("failed result carries data");

	// a newly claimed slot has no previous head
	a_claim_no_next: assert property (@(posedge clk) disable iff (!arst_n)
		(done && claimed) |-> (ok && next_node == '0))
		else $error("claimed slot reports a successor");

endmodule

bind id_slot_register_allocator_unit isra_checker u_isra_checker (.*);
`default_nettype wire
